[hw/rtl/fsb_pkg.sv]
// Package for the forward bilinear splatting block.
// Holds the payload structs, op and register codes, and shared constants.
package fsb_pkg;

  localparam int unsigned DefMaxWidth   = 256;
  localparam int unsigned DefMaxHeight  = 256;
  localparam int unsigned DefSampleBits = 16;

  // Fixed widths that follow from the field formats.
  localparam int unsigned PxW  = 36;  // Q.24 target position, signed
  localparam int unsigned DimW = 13;  // frame sizes up to 4096
  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SPLAT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_T_FRAC       = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic [15:0]        sample0;
    logic [15:0]        sample1;
    logic [15:0]        sample2;
  } in_item_t;

  typedef struct packed {
    logic [31:0] weight_sum;
    logic [47:0] value_sum;
    logic        landed;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_SPLAT,
    CMD_READ,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e     kind;
    logic     rd_in_range;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic [16:0] t_frac;
    logic [8:0]  frame_width;
    logic [8:0]  frame_height;
  } cfg_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [4:0] {
    S_INIT_CLR,
    S_IDLE,
    S_CLR,
    S_RD_ADDR,
    S_RD_DATA,
    S_T2,
    S_BX,
    S_CX,
    S_BY,
    S_CY,
    S_CHECK,
    S_BL0,
    S_BL1,
    S_BL2,
    S_CW,
    S_CV,
    S_WR,
    S_DONE
  } back_state_e;

endpackage

[hw/rtl/forward_splat_bilinear.sv]
// Forward warping by bilinear splatting into saturating accumulator RAMs.
// Throughput: one item at a time in the back end, set by the shared multiplier
// and the read-modify-write of four cells over one RAM port pair.
// Reset: registers return to defaults, then a clearing pass over every cell
// zeroes both stores, during which no item is accepted.
module forward_splat_bilinear
  import fsb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT  = DefMaxHeight,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  cfg_t         cfg_q;
  back_status_t status;
  logic         cmd_valid, cmd_ready;
  cmd_t         cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.t_frac       <= '0;
      cfg_q.frame_width  <= 9'd256;
      cfg_q.frame_height <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_T_FRAC:       cfg_q.t_frac       <= cfg_data_i;
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[8:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  fsb_front #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .status_i(status), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .cmd_o(cmd)
  );

  fsb_back #(
    .MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT), .SampleBits(SAMPLE_BITS)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .cmd_i(cmd), .status_o(status),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

[hw/rtl/fsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/fsb_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on fsb_pkg.
module fsb_front
  import fsb_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  in_item_t     in_data_i,
  input  back_status_t status_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output cmd_t         cmd_o
);

  cmd_t       queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new = '0;
    cmd_new.item = in_data_i;
    unique case (in_data_i.op)
      OP_CLEAR: cmd_new.kind = CMD_CLEAR;
      OP_SPLAT: cmd_new.kind = CMD_SPLAT;
      OP_READ:  cmd_new.kind = CMD_READ;
      default:  cmd_new.kind = CMD_NOP;
    endcase
    cmd_new.rd_in_range = (32'(in_data_i.col) < MaxWidth) &&
                          (32'(in_data_i.row) < MaxHeight);
  end

  // No items are taken while the stores are swept after reset.
  assign in_ready_o  = (count_q != 2'd2) && !status_i.init_busy;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/fsb_back.sv]
// Back end: sequences one command at a time over a shared multiplier and
// the two accumulator RAMs, and holds the result register.
// Depends on fsb_pkg and fsb_ram.
module fsb_back
  import fsb_pkg::*;
#(
  parameter int unsigned MaxWidth   = DefMaxWidth,
  parameter int unsigned MaxHeight  = DefMaxHeight,
  parameter int unsigned SampleBits = DefSampleBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  cmd_t         cmd_i,
  output back_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_data_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned BW    = 16 + SampleBits;   // blended value width
  localparam int unsigned MAW   = BW + 1;            // multiplier operand A
  localparam int unsigned PW    = MAW + 18;
  localparam logic [15:0] SMask = (SampleBits >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << SampleBits) - 32'd1);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [AW-1:0] cnt_q, cnt_d, base_q, base_d;
  logic [16:0] t2_q, t2_d, cellw_q, cellw_d;
  logic signed [PxW-1:0] px_q, px_d, py_q, py_d;
  logic [BW-1:0] blend_q, blend_d, contrib_q, contrib_d;
  logic [1:0]  cell_q, cell_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic signed [MAW-1:0] mul_a;
  logic signed [17:0]    mul_b;
  logic signed [PW-1:0]  prod;

  logic [16:0] t, w0, w1, xm, ym, fx17, fy17;
  logic [DimW-1:0] wdt, hgt;
  logic [11:0] xi, yi;
  logic        in_frame;
  logic [AW-1:0] cell_addr, rd_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   wr_w, rd_w;
  logic [47:0]   wr_v, rd_v;
  logic [32:0]   wsum;
  logic [48:0]   vsum;
  logic [15:0]   s_sel;
  logic          out_free;

  fsb_ram #(.Width(32), .Depth(Depth)) u_weight_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(wr_w),
    .raddr_i(ram_raddr), .rdata_o(rd_w)
  );

  fsb_ram #(.Width(48), .Depth(Depth)) u_value_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(wr_v),
    .raddr_i(ram_raddr), .rdata_o(rd_v)
  );

  // Time and blend weights; t above one acts as one.
  assign t  = (cfg_i.t_frac > OneQ16) ? OneQ16 : cfg_i.t_frac;
  assign w1 = 17'((t - t2_q) << 1);
  assign w0 = OneQ16 - w1 - t2_q;

  always_comb begin
    wdt = DimW'(cfg_i.frame_width);
    if (wdt < DimW'(2)) wdt = DimW'(2);
    else if (wdt > DimW'(MaxWidth)) wdt = DimW'(MaxWidth);
    hgt = DimW'(cfg_i.frame_height);
    if (hgt < DimW'(2)) hgt = DimW'(2);
    else if (hgt > DimW'(MaxHeight)) hgt = DimW'(MaxHeight);
  end

  assign xi   = px_q[PxW-1:24];
  assign yi   = py_q[PxW-1:24];
  assign fx17 = {1'b0, px_q[23:8]};
  assign fy17 = {1'b0, py_q[23:8]};
  assign xm   = OneQ16 - fx17;
  assign ym   = OneQ16 - fy17;
  assign in_frame = !xi[11] && !yi[11] &&
                    (DimW'(xi[10:0]) < wdt - DimW'(1)) &&
                    (DimW'(yi[10:0]) < hgt - DimW'(1));

  always_comb begin
    case (cell_q)
      2'd0:    cell_addr = base_q;
      2'd1:    cell_addr = base_q + AW'(1);
      2'd2:    cell_addr = base_q + AW'(MaxWidth) + AW'(1);
      default: cell_addr = base_q + AW'(MaxWidth);
    endcase
  end

  assign rd_addr = AW'(32'(cmd_q.item.row) * MaxWidth + 32'(cmd_q.item.col));

  always_comb begin
    case (state_q)
      S_BL0:   s_sel = cmd_q.item.sample0 & SMask;
      S_BL1:   s_sel = cmd_q.item.sample1 & SMask;
      default: s_sel = cmd_q.item.sample2 & SMask;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_T2: begin mul_a = MAW'(t);    mul_b = 18'(t); end
      S_BX: begin mul_a = MAW'(t);    mul_b = 18'(cmd_q.item.b_x); end
      S_CX: begin mul_a = MAW'(t2_q); mul_b = 18'(cmd_q.item.c_x); end
      S_BY: begin mul_a = MAW'(t);    mul_b = 18'(cmd_q.item.b_y); end
      S_CY: begin mul_a = MAW'(t2_q); mul_b = 18'(cmd_q.item.c_y); end
      S_BL0: begin mul_a = MAW'(s_sel); mul_b = 18'(w0); end
      S_BL1: begin mul_a = MAW'(s_sel); mul_b = 18'(w1); end
      S_BL2: begin mul_a = MAW'(s_sel); mul_b = 18'(t2_q); end
      S_CW: begin
        case (cell_q)
          2'd0:    begin mul_a = MAW'(xm);   mul_b = 18'(ym); end
          2'd1:    begin mul_a = MAW'(fx17); mul_b = 18'(ym); end
          2'd2:    begin mul_a = MAW'(fx17); mul_b = 18'(fy17); end
          default: begin mul_a = MAW'(xm);   mul_b = 18'(fy17); end
        endcase
      end
      S_CV: begin mul_a = MAW'(blend_q); mul_b = 18'(cellw_q); end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  assign wsum = {1'b0, rd_w} + 33'(cellw_q);
  assign vsum = {1'b0, rd_v} + 49'(contrib_q);

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign status_o.init_busy = (state_q == S_INIT_CLR);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    t2_d        = t2_q;
    cellw_d     = cellw_q;
    px_d        = px_q;
    py_d        = py_q;
    blend_d     = blend_q;
    contrib_d   = contrib_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr;
    ram_raddr   = cell_addr;
    wr_w        = (wsum[32]) ? 32'hFFFF_FFFF : wsum[31:0];
    wr_v        = (vsum[48]) ? 48'hFFFF_FFFF_FFFF : vsum[47:0];

    unique case (state_q)
      S_INIT_CLR, S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        wr_w      = '0;
        wr_v      = '0;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(Depth - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT_CLR) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          cmd_d  = cmd_i;
          cell_d = '0;
          out_d  = '0;
          unique case (cmd_i.kind)
            CMD_CLEAR: state_d = S_CLR;
            CMD_SPLAT: state_d = S_T2;
            CMD_READ:  state_d = cmd_i.rd_in_range ? S_RD_ADDR : S_DONE;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_RD_ADDR: begin
        ram_raddr = rd_addr;
        state_d   = S_RD_DATA;
      end
      S_RD_DATA: begin
        out_d.weight_sum = rd_w;
        out_d.value_sum  = rd_v;
        state_d          = S_DONE;
      end
      S_T2: begin
        t2_d    = 17'((prod[33:0] + 34'd32768) >> 16);
        state_d = S_BX;
      end
      S_BX: begin
        px_d    = PxW'({cmd_q.item.col, 24'd0}) + PxW'(prod);
        state_d = S_CX;
      end
      S_CX: begin
        px_d    = px_q + PxW'(prod);
        state_d = S_BY;
      end
      S_BY: begin
        py_d    = PxW'({cmd_q.item.row, 24'd0}) + PxW'(prod);
        state_d = S_CY;
      end
      S_CY: begin
        py_d    = py_q + PxW'(prod);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        base_d  = AW'(32'(yi[10:0]) * MaxWidth + 32'(xi[10:0]));
        state_d = in_frame ? S_BL0 : S_DONE;
      end
      S_BL0: begin
        blend_d = BW'(prod);
        state_d = S_BL1;
      end
      S_BL1: begin
        blend_d = blend_q + BW'(prod);
        state_d = S_BL2;
      end
      S_BL2: begin
        blend_d = blend_q + BW'(prod);
        state_d = S_CW;
      end
      S_CW: begin
        cellw_d = 17'(prod[PW-1:16]);
        state_d = S_CV;
      end
      S_CV: begin
        // The RAM read of the cell is issued here and returns next cycle.
        contrib_d = BW'(prod[PW-1:16]);
        state_d   = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        cell_d = cell_q + 2'd1;
        if (cell_q == 2'd3) begin
          out_d.landed = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_CW;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    base_q    <= base_d;
    t2_q      <= t2_d;
    cellw_q   <= cellw_d;
    px_q      <= px_d;
    py_q      <= py_d;
    blend_q   <= blend_d;
    contrib_q <= contrib_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT_CLR;
      cnt_q       <= '0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cell_q      <= cell_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the forward bilinear splatting block.
// Depends on fsb_pkg and forward_splat_bilinear. Holds its own model of both accumulator
// stores, a queued driver, a randomly stalling receiver and a checker.
`timescale 1ns / 1ps

module tb;
  import fsb_pkg::*;

  localparam int unsigned Cells     = DefMaxWidth * DefMaxHeight;
  localparam logic [1:0]  OpUnused  = 2'd3;
  localparam int unsigned QuietWait = 40;
  localparam int unsigned WdLimit   = 250000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_T_FRAC;
  logic [16:0] cfg_data = '0;

  forward_splat_bilinear i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copies of the accumulators and registers.
  logic [31:0] weight_acc [Cells];
  logic [47:0] value_acc  [Cells];
  logic [16:0] t_reg = '0;
  logic [8:0]  width_reg = 9'd256;
  logic [8:0]  height_reg = 9'd256;

  in_item_t  pending_items [$];
  out_item_t expected_sums [$];
  int        touched_cells [$];
  int        fails = 0;
  bit        no_idle = 1'b0;
  bit        long_stall_req = 1'b0;
  bit        long_stall_done = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        stall_cnt = 0;
  int        quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_stores();
    for (int i = 0; i < Cells; i++) begin
      weight_acc[i] = '0;
      value_acc[i]  = '0;
    end
  endfunction

  function automatic longint unsigned dim_clamp(logic [8:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 64'(v);
  endfunction

  function automatic void accumulate(int idx, longint unsigned w, longint unsigned blended);
    longint unsigned ws;
    longint unsigned vs;
    ws = longint'(weight_acc[idx]) + w;
    vs = longint'(value_acc[idx]) + ((blended * w) >> 16);
    weight_acc[idx] = (ws > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ws[31:0];
    value_acc[idx]  = (vs > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : vs[47:0];
  endfunction

  function automatic out_item_t predict_sums(in_item_t it);
    out_item_t r;
    longint t, t2, w0, w1, w2, px, py, xi, yi, fx, fy, blended, wdt, hgt;
    int base;
    r = '0;
    case (it.op)
      OP_CLEAR: clear_stores();
      OP_READ: begin
        r.weight_sum = weight_acc[it.row * DefMaxWidth + it.col];
        r.value_sum  = value_acc[it.row * DefMaxWidth + it.col];
      end
      OP_SPLAT: begin
        t  = (t_reg > 17'h10000) ? 65536 : t_reg;
        t2 = (t * t + 32768) >>> 16;
        w2 = t2;
        w1 = 2 * (t - t2);
        w0 = 65536 - w1 - w2;
        wdt = dim_clamp(width_reg, DefMaxWidth);
        hgt = dim_clamp(height_reg, DefMaxHeight);
        px = longint'(it.col) * 64'd16777216 + t * longint'(it.b_x) + t2 * longint'(it.c_x);
        py = longint'(it.row) * 64'd16777216 + t * longint'(it.b_y) + t2 * longint'(it.c_y);
        // Bias to a positive value so the shifts floor and mask correctly.
        xi = ((px + (64'sd1 <<< 40)) >>> 24) - 65536;
        yi = ((py + (64'sd1 <<< 40)) >>> 24) - 65536;
        fx = ((px + (64'sd1 <<< 40)) >>> 8) & 64'hFFFF;
        fy = ((py + (64'sd1 <<< 40)) >>> 8) & 64'hFFFF;
        if (xi >= 0 && xi < wdt - 1 && yi >= 0 && yi < hgt - 1) begin
          blended = w0 * it.sample0 + w1 * it.sample1 + w2 * it.sample2;
          base = int'(yi) * DefMaxWidth + int'(xi);
          accumulate(base, ((65536 - fx) * (65536 - fy)) >> 16, blended);
          accumulate(base + 1, (fx * (65536 - fy)) >> 16, blended);
          accumulate(base + DefMaxWidth + 1, (fx * fy) >> 16, blended);
          accumulate(base + DefMaxWidth, ((65536 - fx) * fy) >> 16, blended);
          r.landed = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: one transaction at a time from the pending queue.
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      expected_sums.push_back(predict_sums(in_data));
      if (no_idle && pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
        send_gap <= no_idle ? 0 : $urandom_range(0, 17);
      end
    end else if (!in_valid && rst_ni) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fails++;
      end else begin
        out_item_t e;
        e = expected_sums.pop_front();
        if (e.weight_sum !== out_data.weight_sum) begin
          $display("%0t: weight_sum expected %h actual %h", $time, e.weight_sum,
                   out_data.weight_sum);
          fails++;
        end
        if (e.value_sum !== out_data.value_sum) begin
          $display("%0t: value_sum expected %h actual %h", $time, e.value_sum,
                   out_data.value_sum);
          fails++;
        end
        if (e.landed !== out_data.landed) begin
          $display("%0t: landed expected %b actual %b", $time, e.landed, out_data.landed);
          fails++;
        end
      end
    end
    if (long_stall_req && !long_stall_done) begin
      long_stall_done <= 1'b1;
      stall_cnt <= 400;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      if (stall_cnt == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      recv_gap <= no_idle ? 0 : $urandom_range(0, 17);
      if (!no_idle) out_ready <= 1'b0;
    end else if (!out_ready && rst_ni) begin
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      else out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdLimit) begin
      $display("[forward_splat_bilinear] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_T_FRAC:       t_reg = val;
      CFG_FRAME_WIDTH:  width_reg = val[8:0];
      CFG_FRAME_HEIGHT: height_reg = val[8:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_sums.size() > 0)
      @(posedge clk_i);
    repeat (QuietWait) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic [1:0] op, int c, int r);
    in_item_t it;
    it = '0;
    it.op  = op;
    it.col = c[7:0];
    it.row = r[7:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [159:0] rnd;
    int sel, wd, ht, cell_idx;
    sel = $urandom_range(0, 999);
    wd = int'(dim_clamp(width_reg, DefMaxWidth));
    ht = int'(dim_clamp(height_reg, DefMaxHeight));
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = rnd[$bits(in_item_t)-1:0];
    if (sel < 3) begin
      it.op = OP_CLEAR;
      touched_cells.delete();
    end else if (sel < 13) begin
      it.op = OpUnused;
    end else if (sel < 380) begin
      it.op = OP_READ;
      if (touched_cells.size() > 0 && $urandom_range(0, 3) != 0) begin
        cell_idx = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
        it.col = 8'(cell_idx % DefMaxWidth);
        it.row = 8'(cell_idx / DefMaxWidth);
      end
    end else begin
      it.op = OP_SPLAT;
      if ($urandom_range(0, 6) != 0) begin
        // Small displacement around a source inside the frame, so most land.
        it.col = 8'($urandom_range(0, wd - 1));
        it.row = 8'($urandom_range(0, ht - 1));
        it.b_x = 16'($urandom_range(0, 1023) - 512);
        it.b_y = 16'($urandom_range(0, 1023) - 512);
        it.c_x = 16'($urandom_range(0, 511) - 256);
        it.c_y = 16'($urandom_range(0, 511) - 256);
      end
      cell_idx = it.row * DefMaxWidth + it.col;
      if (touched_cells.size() < 200) begin
        touched_cells.push_back(cell_idx);
        if (cell_idx + DefMaxWidth + 1 < Cells) begin
          touched_cells.push_back(cell_idx + DefMaxWidth + 1);
        end
      end
    end
    return it;
  endfunction

  initial begin
    logic [16:0] t_set [8]  = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd70000,
                                17'd0, 17'd0, 17'd0};
    logic [8:0]  w_set [8]  = '{9'd256, 9'd2, 9'd0, 9'd16, 9'd511, 9'd1, 9'd0, 9'd0};
    logic [8:0]  h_set [8]  = '{9'd256, 9'd2, 9'd1, 9'd16, 9'd300, 9'd255, 9'd0, 9'd0};
    in_item_t it;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CFG_T_FRAC, 17'd65536);
    write_reg(CFG_FRAME_WIDTH, 17'd256);
    write_reg(CFG_FRAME_HEIGHT, 17'd256);

    // Directed opening: extremes, every op, edges of the frame.
    pending_items.push_back(make_item(OP_READ, 0, 0));
    it = make_item(OP_SPLAT, 10, 20);
    it.sample0 = 16'hFFFF; it.sample1 = 16'hFFFF; it.sample2 = 16'hFFFF;
    it.b_x = 16'sd128; it.c_y = -16'sd64;
    pending_items.push_back(it);
    pending_items.push_back(make_item(OP_READ, 10, 20));
    pending_items.push_back(make_item(OP_READ, 11, 20));
    pending_items.push_back(make_item(OP_READ, 10, 19));
    pending_items.push_back(make_item(OP_READ, 11, 19));
    it = make_item(OP_SPLAT, 254, 254);
    it.sample1 = 16'h8001;
    pending_items.push_back(it);
    it = make_item(OP_SPLAT, 255, 255);
    pending_items.push_back(it);
    it = make_item(OP_SPLAT, 0, 0);
    it.b_x = 16'sh7FFF; it.b_y = 16'sh7FFF; it.c_x = 16'sh7FFF; it.c_y = 16'sh7FFF;
    pending_items.push_back(it);
    it = make_item(OP_SPLAT, 255, 255);
    it.b_x = -16'sh8000; it.b_y = -16'sh8000; it.c_x = -16'sh8000; it.c_y = -16'sh8000;
    pending_items.push_back(it);
    it = make_item(OP_SPLAT, 0, 0);
    it.b_x = -16'sd1;
    pending_items.push_back(it);
    it = make_item(OP_SPLAT, 3, 3);
    it.b_x = 16'sh0080; it.b_y = 16'sh0040; it.c_x = -16'sh0100; it.c_y = 16'sh0100;
    it.sample0 = 16'h1234; it.sample2 = 16'hFFFF;
    pending_items.push_back(it);
    pending_items.push_back(make_item(OP_READ, 254, 254));
    pending_items.push_back(make_item(OP_READ, 255, 255));
    pending_items.push_back(make_item(OP_READ, 3, 3));
    pending_items.push_back(make_item(OpUnused, 255, 255));
    pending_items.push_back(make_item(OP_CLEAR, 0, 0));
    pending_items.push_back(make_item(OP_READ, 10, 20));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 5) begin
        t_set[ph] = 17'($urandom_range(0, 17'h1FFFF));
        w_set[ph] = 9'($urandom_range(0, 511));
        h_set[ph] = 9'($urandom_range(0, 511));
      end
      write_reg(CFG_T_FRAC, t_set[ph]);
      write_reg(CFG_FRAME_WIDTH, {8'd0, w_set[ph]});
      write_reg(CFG_FRAME_HEIGHT, {8'd0, h_set[ph]});
      touched_cells.delete();
      no_idle = (ph == 3);
      for (int n = 0; n < 160; n++) pending_items.push_back(random_item());
      // Hold the receiver off for a long while so the block backs up.
      if (ph == 2) long_stall_req = 1'b1;
      wait_drained();
    end

    if (fails == 0) begin
      $display("[forward_splat_bilinear] OK");
    end else begin
      $display("[forward_splat_bilinear] ERROR");
    end
    $finish;
  end

endmodule
